@@ design/owsp_pkg.sv @@
// ----------------------------------------------------------------------------
// owsp_pkg
// Shared types, constants and the message checksum for the wind sensor
// pulse decoder.
// ----------------------------------------------------------------------------
package owsp_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int MSG_BITS  = 36;
	localparam int POS_W     = 6;
	localparam int CQ_DEPTH  = 4;
	localparam int CQ_PTR_W  = 2;
	localparam int CQ_CNT_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_GAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT   = 2'd2;

	localparam logic [CFG_W-1:0] BLOCK_GAP_RST = 16'd30000;
	localparam logic [CFG_W-1:0] SYNC_GAP_RST  = 16'd7000;
	localparam logic [CFG_W-1:0] ONE_BIT_RST   = 16'd3300;

	localparam logic [POS_W-1:0] POS_FULL = POS_W'(MSG_BITS);

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] SLOT_FIRST  = 2'd0;
	localparam logic [1:0] SLOT_SECOND = 2'd1;
	localparam logic [1:0] SLOT_IDLE   = 2'd2;

	// classified item handed from the front to the back
	typedef struct packed {
		logic op;
		logic gt_block;
		logic gt_sync;
		logic is_one;
	} cmd_t;

	typedef struct packed {
		logic [7:0] peak;
		logic [7:0] gust;
		logic [8:0] dir;
		logic       pair;
		logic       upd;
	} res_t;

	function automatic logic checksum_ok(input logic [MSG_BITS-1:0] msg);
		logic [3:0] sum;
		sum = 4'hf;
		for (int i = 0; i < 8; i++) begin
			sum = sum - msg[4*i +: 4];
		end
		return sum == msg[35:32];
	endfunction

endpackage

@@ design/owsp_front.sv @@
// ----------------------------------------------------------------------------
// owsp_front
// Accepts items, measures the edge interval and classifies it against the
// configured gaps; holds the configuration registers.
// ----------------------------------------------------------------------------
module owsp_front import owsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 operation,
	input  logic [TIME_BITS-1:0] edge_time_us,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output cmd_t                 q_cmd
);

	logic [TIME_BITS-1:0] last_edge_q;
	logic [CFG_W-1:0]     block_gap_q;
	logic [CFG_W-1:0]     sync_gap_q;
	logic [CFG_W-1:0]     one_bit_q;
	logic [TIME_BITS-1:0] dur;

	assign q_push = push && !q_full;
	assign dur    = edge_time_us - last_edge_q;

	always_comb begin
		q_cmd.op       = operation;
		q_cmd.gt_block = dur > TIME_BITS'(block_gap_q);
		q_cmd.gt_sync  = dur > TIME_BITS'(sync_gap_q);
		q_cmd.is_one   = dur >= TIME_BITS'(one_bit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
		end else if (q_push && operation == OP_EDGE) begin
			last_edge_q <= edge_time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_gap_q <= BLOCK_GAP_RST;
			sync_gap_q  <= SYNC_GAP_RST;
			one_bit_q   <= ONE_BIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BLOCK_GAP: block_gap_q <= cfg_data;
				REG_SYNC_GAP:  sync_gap_q  <= cfg_data;
				REG_ONE_BIT:   one_bit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ design/owsp_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// owsp_cmd_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module owsp_cmd_queue import owsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = cnt_q == CQ_CNT_W'(CQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/owsp_back.sv @@
// ----------------------------------------------------------------------------
// owsp_back
// Carries out classified items: message assembly, pair decode, wind stores,
// and a two-entry result queue towards the output.
// ----------------------------------------------------------------------------
module owsp_back import owsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] wind_speed_peak,
	output logic [7:0] wind_gust,
	output logic [8:0] wind_direction,
	output logic       pair_complete,
	output logic       wind_updated
);

	logic [1:0]          slot_q;
	logic [POS_W-1:0]    pos_q;
	logic                pos_valid_q;
	logic [MSG_BITS-1:0] msg0_q;
	logic [MSG_BITS-1:0] msg1_q;
	logic [7:0]          peak_q;
	logic [7:0]          gust_q;
	logic [8:0]          dir_q;

	logic [1:0]          slot_n;
	logic [POS_W-1:0]    pos_n;
	logic                pos_valid_n;
	logic [MSG_BITS-1:0] msg0_n;
	logic [MSG_BITS-1:0] msg1_n;
	logic [7:0]          peak_n;
	logic [7:0]          gust_n;
	logic [8:0]          dir_n;
	res_t                res;

	res_t                oq_q [2];
	logic                oq_wr_q;
	logic                oq_rd_q;
	logic [1:0]          oq_cnt_q;
	logic                out_pop;

	assign cmd_pop = cmd_valid && oq_cnt_q != 2'd2;
	assign empty   = oq_cnt_q == 2'd0;
	assign out_pop = pop && !empty;

	always_comb begin
		slot_n      = slot_q;
		pos_n       = pos_q;
		pos_valid_n = pos_valid_q;
		msg0_n      = msg0_q;
		msg1_n      = msg1_q;
		peak_n      = peak_q;
		gust_n      = gust_q;
		dir_n       = dir_q;
		res.peak    = peak_q;
		res.gust    = gust_q;
		res.dir     = dir_q;
		res.pair    = 1'b0;
		res.upd     = 1'b0;
		if (cmd.op == OP_READ) begin
			peak_n = '0;
		end else begin
			if (cmd.gt_block) begin
				slot_n = SLOT_FIRST;
			end
			if (cmd.gt_sync) begin
				if (pos_valid_q && pos_q == POS_FULL) begin
					if (slot_n == SLOT_FIRST) begin
						slot_n = SLOT_SECOND;
					end else if (slot_n == SLOT_SECOND) begin
						slot_n   = SLOT_IDLE;
						res.pair = 1'b1;
						// a wind frame has bits 9 and 10 set in the first message
						if (checksum_ok(msg0_q) && msg0_q[10:9] == 2'b11
								&& checksum_ok(msg1_q)) begin
							res.upd = 1'b1;
							if (msg0_q[31:24] > peak_q) begin
								peak_n = msg0_q[31:24];
							end
							gust_n = msg1_q[31:24];
							dir_n  = msg1_q[23:15];
						end
					end
				end
				pos_n       = '0;
				pos_valid_n = 1'b1;
			end else if (slot_n inside {SLOT_FIRST, SLOT_SECOND} && pos_valid_q) begin
				if (pos_q < POS_FULL) begin
					if (slot_n == SLOT_FIRST) begin
						msg0_n[pos_q] = cmd.is_one;
					end else begin
						msg1_n[pos_q] = cmd.is_one;
					end
					pos_n = pos_q + 1'b1;
				end else begin
					// too many bits: drop until the next sync
					pos_n       = '0;
					pos_valid_n = 1'b0;
				end
			end
			res.peak = peak_n;
			res.gust = gust_n;
			res.dir  = dir_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= SLOT_IDLE;
			pos_q       <= '0;
			pos_valid_q <= 1'b0;
			msg0_q      <= '0;
			msg1_q      <= '0;
			peak_q      <= '0;
			gust_q      <= '0;
			dir_q       <= '0;
		end else if (cmd_pop) begin
			slot_q      <= slot_n;
			pos_q       <= pos_n;
			pos_valid_q <= pos_valid_n;
			msg0_q      <= msg0_n;
			msg1_q      <= msg1_n;
			peak_q      <= peak_n;
			gust_q      <= gust_n;
			dir_q       <= dir_n;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (cmd_pop) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (out_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			if (cmd_pop && !out_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (out_pop && !cmd_pop) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	assign wind_speed_peak = oq_q[oq_rd_q].peak;
	assign wind_gust       = oq_q[oq_rd_q].gust;
	assign wind_direction  = oq_q[oq_rd_q].dir;
	assign pair_complete   = oq_q[oq_rd_q].pair;
	assign wind_updated    = oq_q[oq_rd_q].upd;

endmodule

@@ design/ook_wind_sensor_pulse_decoder.sv @@
// ----------------------------------------------------------------------------
// ook_wind_sensor_pulse_decoder
// Decodes falling-edge timestamps of an OOK wind sensor into peak speed,
// gust and direction; read requests return the values and clear the peak.
// ----------------------------------------------------------------------------
// a 4-entry item queue and a 2-entry result queue let each side stall alone
// throughput: 1 item per cycle while not full; items are classified, then
// executed by the back, one queued item a cycle while results have room
// reset: asynchronous, clears state and loads the default gap settings
module ook_wind_sensor_pulse_decoder import owsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 operation,
	input  logic [TIME_BITS-1:0] edge_time_us,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           wind_speed_peak,
	output logic [7:0]           wind_gust,
	output logic [8:0]           wind_direction,
	output logic                 pair_complete,
	output logic                 wind_updated,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic q_push;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cmd_t q_wr_cmd;
	cmd_t q_rd_cmd;

	assign full = q_full;

	owsp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.operation    (operation),
		.edge_time_us (edge_time_us),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_wr_cmd)
	);

	owsp_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_cmd),
		.empty   (q_empty)
	);

	owsp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (!q_empty),
		.cmd             (q_rd_cmd),
		.cmd_pop         (q_pop),
		.pop             (pop),
		.empty           (empty),
		.wind_speed_peak (wind_speed_peak),
		.wind_gust       (wind_gust),
		.wind_direction  (wind_direction),
		.pair_complete   (pair_complete),
		.wind_updated    (wind_updated)
	);

endmodule
